### src/prfq_pkg.sv
// Package for the pulse rate finger qualifier: shared types, register
// indexes, reset values and the control bundle passed between the finger and
// rate units. No dependencies.
`default_nettype none

package prfq_pkg;

   typedef logic [17:0]        level_type;
   typedef logic signed [13:0] raw_rate_type;
   typedef logic signed [10:0] value_type;
   typedef logic [7:0]         bpm_type;
   typedef logic [3:0]         count_type;
   typedef logic [2:0]         csr_index_type;

   localparam value_type NONE_CODE = -11'sd999;

   localparam csr_index_type CSR_ABSENT_THRESHOLD = 3'd0;
   localparam csr_index_type CSR_STRONG_THRESHOLD = 3'd1;
   localparam csr_index_type CSR_CONFIRM_WINDOWS  = 3'd2;
   localparam csr_index_type CSR_RATE_MIN         = 3'd3;
   localparam csr_index_type CSR_RATE_MAX         = 3'd4;
   localparam csr_index_type CSR_JUMP_LIMIT       = 3'd5;

   localparam level_type RESET_ABSENT_THRESHOLD = 18'd8000;
   localparam level_type RESET_STRONG_THRESHOLD = 18'd15000;
   localparam count_type RESET_CONFIRM_WINDOWS  = 4'd3;
   localparam bpm_type   RESET_RATE_MIN         = 8'd30;
   localparam bpm_type   RESET_RATE_MAX         = 8'd220;
   localparam bpm_type   RESET_JUMP_LIMIT       = 8'd30;

   typedef struct packed {
      level_type absent_threshold;
      level_type strong_threshold;
      count_type confirm_windows;
      bpm_type   rate_min;
      bpm_type   rate_max;
      bpm_type   jump_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      PHASE_NONE   = 2'd0,
      PHASE_WARM   = 2'd1,
      PHASE_STABLE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ACT_KEEP  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_BLANK = 2'd2,
      ACT_TRACK = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      phase_type  phase;
   } finger_ctrl_type;

endpackage

`default_nettype wire

### src/pulse_rate_finger_qualifier.sv
// Pulse rate finger qualifier, top level: input register, finger and rate
// units, result register. Depends on prfq_pkg, prfq_csr, prfq_finger, prfq_rate.
//
// Usage: one window summary (mean infrared level, raw pulse rate, raw oxygen)
// is a transfer on the req_ channel; each one yields exactly one transfer on
// the rsp_ channel with the shown rate, shown oxygen and finger status.
// A summary is first held in an input register; once the result register is free,
// the finger state machine and the rate history update and the result is loaded
// into the result register. Throughput is one summary per cycle while the
// receiver does not stall: all the work sits in one combinational pass between
// the two registers, and req_ready stays high while the result register is
// empty or being taken. When the receiver stalls, the result stays in the result
// register and one further summary waits in the input register; req_ready then
// drops. Synchronous reset empties both registers, returns the finger state to
// no finger, fills the history and shown values with -999 and loads the register
// reset values. The user must write registers over the csr_ port only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module pulse_rate_finger_qualifier import prfq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire level_type     req_ir_average,
   input  wire raw_rate_type  req_raw_rate,
   input  wire value_type     req_raw_oxygen,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output value_type          rsp_shown_rate,
   output value_type          rsp_shown_oxygen,
   output logic [1:0]         rsp_finger_status,
   input  wire logic          csr_write,
   input  wire csr_index_type csr_index,
   input  wire level_type     csr_data
);

   logic            in_valid_ff;
   logic            in_valid_in;
   level_type       ir_ff;
   raw_rate_type    rate_ff;
   value_type       oxy_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   value_type       out_rate_ff;
   value_type       out_oxy_ff;
   logic [1:0]      out_status_ff;
   logic            out_free;
   logic            advance;
   logic            req_take;
   cfg_type         cfg;
   finger_ctrl_type ctrl;
   value_type       next_rate;
   value_type       next_oxy;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ir_ff   <= req_ir_average;
         rate_ff <= req_raw_rate;
         oxy_ff  <= req_raw_oxygen;
      end
      if (advance) begin
         out_rate_ff   <= next_rate;
         out_oxy_ff    <= next_oxy;
         out_status_ff <= ctrl.phase;
      end
   end

   prfq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   prfq_finger u_finger (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ir_average (ir_ff),
      .cfg        (cfg),
      .ctrl       (ctrl)
   );

   prfq_rate u_rate (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ctrl         (ctrl),
      .raw_rate     (rate_ff),
      .raw_oxygen   (oxy_ff),
      .cfg          (cfg),
      .shown_rate   (next_rate),
      .shown_oxygen (next_oxy)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_shown_rate    = out_rate_ff;
   assign rsp_shown_oxygen  = out_oxy_ff;
   assign rsp_finger_status = out_status_ff;

endmodule

`default_nettype wire

### src/prfq_csr.sv
// Configuration registers of the pulse rate finger qualifier.
// Depends on prfq_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module prfq_csr import prfq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write,
   input  wire csr_index_type csr_index,
   input  wire level_type     csr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ABSENT_THRESHOLD: cfg_in.absent_threshold = csr_data;
            CSR_STRONG_THRESHOLD: cfg_in.strong_threshold = csr_data;
            CSR_CONFIRM_WINDOWS:  cfg_in.confirm_windows  = csr_data[3:0];
            CSR_RATE_MIN:         cfg_in.rate_min         = csr_data[7:0];
            CSR_RATE_MAX:         cfg_in.rate_max         = csr_data[7:0];
            CSR_JUMP_LIMIT:       cfg_in.jump_limit       = csr_data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.absent_threshold <= RESET_ABSENT_THRESHOLD;
         cfg_ff.strong_threshold <= RESET_STRONG_THRESHOLD;
         cfg_ff.confirm_windows  <= RESET_CONFIRM_WINDOWS;
         cfg_ff.rate_min         <= RESET_RATE_MIN;
         cfg_ff.rate_max         <= RESET_RATE_MAX;
         cfg_ff.jump_limit       <= RESET_JUMP_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/prfq_finger.sv
// Finger presence state machine: classifies the mean infrared level and counts
// strong windows. Depends on prfq_pkg for the phase, action and cfg types.
`default_nettype none

module prfq_finger import prfq_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire level_type ir_average,
   input  wire cfg_type   cfg,
   output finger_ctrl_type ctrl
);

   phase_type  phase_ff;
   phase_type  phase_in;
   count_type  count_ff;
   count_type  count_in;
   action_type action;
   logic [4:0] count_next;
   logic [4:0] confirm;

   always_comb begin
      count_next = {1'b0, count_ff} + 5'd1;
      confirm    = {1'b0, cfg.confirm_windows};
      phase_in   = phase_ff;
      count_in   = count_ff;
      action     = ACT_KEEP;
      if (ir_average < cfg.absent_threshold) begin
         phase_in = PHASE_NONE;
         count_in = '0;
         action   = ACT_CLEAR;
      end else if (ir_average < cfg.strong_threshold) begin
         if (phase_ff == PHASE_NONE) begin
            phase_in = PHASE_WARM;
            action   = ACT_BLANK;
         end
      end else if (count_next >= confirm || phase_ff == PHASE_STABLE) begin
         phase_in = PHASE_STABLE;
         count_in = (count_next > confirm) ? confirm[3:0] : count_next[3:0];
         action   = ACT_TRACK;
      end else begin
         count_in = count_next[3:0];
         action   = ACT_BLANK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NONE;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign ctrl.action = action;
   assign ctrl.phase  = phase_in;

endmodule

`default_nettype wire

### src/prfq_rate.sv
// Rate tracking: three-entry history, median, jump guard and held rate.
// Depends on prfq_pkg for value types, NONE_CODE and the finger control bundle.
`default_nettype none

module prfq_rate import prfq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire finger_ctrl_type ctrl,
   input  wire raw_rate_type    raw_rate,
   input  wire value_type       raw_oxygen,
   input  wire cfg_type         cfg,
   output value_type            shown_rate,
   output value_type            shown_oxygen
);

   function automatic value_type median3(value_type a, value_type b, value_type c);
      value_type lo;
      value_type hi;
      value_type mid;
      lo  = (a < b) ? a : b;
      hi  = (a < b) ? b : a;
      mid = (hi < c) ? hi : c;
      return (lo > mid) ? lo : mid;
   endfunction

   value_type    hist_ff [3];
   value_type    hist_in [3];
   value_type    hist_wr [3];
   logic [1:0]   slot_ff;
   logic [1:0]   slot_in;
   logic [1:0]   wr_slot;
   logic [1:0]   next_slot;
   value_type    held_ff;
   value_type    held_in;
   value_type    cur_rate_ff;
   value_type    cur_rate_in;
   value_type    cur_oxy_ff;
   value_type    cur_oxy_in;
   value_type    min_value;
   raw_rate_type min_raw;
   raw_rate_type max_raw;
   logic         rate_ok;
   logic         all_ok;
   logic         held_ok;
   value_type    med;
   logic signed [11:0] diff;
   logic [11:0]  magnitude;
   logic         jump_over;

   always_comb begin
      min_value = $signed({3'b000, cfg.rate_min});
      min_raw   = $signed({6'b000000, cfg.rate_min});
      max_raw   = $signed({6'b000000, cfg.rate_max});
      rate_ok   = (raw_rate >= min_raw) && (raw_rate <= max_raw);
      wr_slot   = (slot_ff == 2'd3) ? 2'd0 : slot_ff;
      next_slot = (wr_slot == 2'd2) ? 2'd0 : wr_slot + 2'd1;
      for (int i = 0; i < 3; i++) begin
         hist_wr[i] = (wr_slot == 2'(i)) ? raw_rate[10:0] : hist_ff[i];
      end
      all_ok    = (hist_wr[0] >= min_value) && (hist_wr[1] >= min_value) &&
                  (hist_wr[2] >= min_value);
      med       = median3(hist_wr[0], hist_wr[1], hist_wr[2]);
      held_ok   = held_ff >= min_value;
      diff      = {med[10], med} - {held_ff[10], held_ff};
      magnitude = diff[11] ? 12'(-diff) : 12'(diff);
      jump_over = magnitude > {4'b0000, cfg.jump_limit};

      hist_in     = hist_ff;
      slot_in     = slot_ff;
      held_in     = held_ff;
      cur_rate_in = cur_rate_ff;
      cur_oxy_in  = cur_oxy_ff;
      case (ctrl.action)
         ACT_CLEAR: begin
            for (int i = 0; i < 3; i++) begin
               hist_in[i] = NONE_CODE;
            end
            slot_in     = '0;
            held_in     = NONE_CODE;
            cur_rate_in = NONE_CODE;
            cur_oxy_in  = NONE_CODE;
         end
         ACT_BLANK: begin
            cur_rate_in = NONE_CODE;
            cur_oxy_in  = NONE_CODE;
         end
         ACT_TRACK: begin
            cur_oxy_in = raw_oxygen;
            if (rate_ok) begin
               hist_in = hist_wr;
               slot_in = next_slot;
               if (all_ok && held_ok && jump_over) begin
                  cur_rate_in = held_ff;
               end else if (all_ok) begin
                  cur_rate_in = med;
                  held_in     = med;
               end else begin
                  cur_rate_in = raw_rate[10:0];
                  held_in     = raw_rate[10:0];
               end
            end else begin
               cur_rate_in = held_ok ? held_ff : NONE_CODE;
            end
         end
         default: begin
            cur_rate_in = cur_rate_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= NONE_CODE;
         end
         slot_ff     <= '0;
         held_ff     <= NONE_CODE;
         cur_rate_ff <= NONE_CODE;
         cur_oxy_ff  <= NONE_CODE;
      end else if (advance) begin
         hist_ff     <= hist_in;
         slot_ff     <= slot_in;
         held_ff     <= held_in;
         cur_rate_ff <= cur_rate_in;
         cur_oxy_ff  <= cur_oxy_in;
      end
   end

   assign shown_rate   = cur_rate_in;
   assign shown_oxygen = cur_oxy_in;

endmodule

`default_nettype wire

### src/prfq_checker.sv
// Port-level checker for the pulse rate finger qualifier and its bind statement.
// Depends on prfq_pkg for NONE_CODE and the phase codes.
`default_nettype none

module prfq_checker import prfq_pkg::*; (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire value_type     rsp_shown_rate,
   input wire value_type     rsp_shown_oxygen,
   input wire logic [1:0]    rsp_finger_status
);

   // A stalled result holds until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shown_rate) &&
      $stable(rsp_shown_oxygen) && $stable(rsp_finger_status))
      else $error("stalled result changed");

   // Leaving reset, no result is pending.
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

   // Without a stable finger, nothing is reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finger_status != PHASE_STABLE |->
      rsp_shown_rate == NONE_CODE && rsp_shown_oxygen == NONE_CODE)
      else $error("value reported without a stable finger");

   // A reported rate is never negative unless it is the none code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown_rate != NONE_CODE |-> !rsp_shown_rate[10])
      else $error("negative shown rate");

endmodule

bind pulse_rate_finger_qualifier prfq_checker u_prfq_checker (.*);

`default_nettype wire

### dv/tb_pulse_rate_finger_qualifier.sv
// Testbench for pulse_rate_finger_qualifier: directed, register and random tests
// checked against an in-bench prediction of the finger state and shown values.
// Depends on prfq_pkg and the pulse_rate_finger_qualifier RTL.
`timescale 1ns / 100ps

module tb_pulse_rate_finger_qualifier;
   import prfq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam raw_rate_type NO_RATE = -14'sd999;

   typedef struct packed {
      value_type  rate;
      value_type  oxygen;
      logic [1:0] status;
   } shown_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   level_type     req_ir_average = '0;
   raw_rate_type  req_raw_rate = '0;
   value_type     req_raw_oxygen = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   value_type     rsp_shown_rate;
   value_type     rsp_shown_oxygen;
   logic [1:0]    rsp_finger_status;
   logic          csr_write = 1'b0;
   csr_index_type csr_index = CSR_ABSENT_THRESHOLD;
   level_type     csr_data = '0;

   shown_type shown_queue[$];
   int        mismatches = 0;
   int        cycle_count = 0;
   int        sender_gap_pct = 0;
   int        receiver_stall_pct = 0;
   int        rate_center = 75;

   int        cfg_absent;
   int        cfg_strong;
   int        cfg_confirm;
   int        cfg_rate_min;
   int        cfg_rate_max;
   int        cfg_jump;

   phase_type pr_phase;
   int        pr_strong;
   int        pr_history[3];
   int        pr_slot;
   int        pr_held;
   int        pr_rate;
   int        pr_oxygen;

   pulse_rate_finger_qualifier DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ir_average    (req_ir_average),
      .req_raw_rate      (req_raw_rate),
      .req_raw_oxygen    (req_raw_oxygen),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_shown_rate    (rsp_shown_rate),
      .rsp_shown_oxygen  (rsp_shown_oxygen),
      .rsp_finger_status (rsp_finger_status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
   end

   always @(posedge clock) begin : check_result
      shown_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (shown_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cycle %0d: result transfer with nothing expected", cycle_count);
         end else begin
            want = shown_queue.pop_front();
            if (rsp_shown_rate !== want.rate || rsp_shown_oxygen !== want.oxygen ||
                rsp_finger_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: rate %0d/%0d oxygen %0d/%0d status %0d/%0d %s",
                           cycle_count, $signed(want.rate), $signed(rsp_shown_rate),
                           $signed(want.oxygen), $signed(rsp_shown_oxygen),
                           want.status, rsp_finger_status, "(expected/actual)");
            end
         end
      end
   end

   function automatic void clear_tracking();
      pr_phase   = PHASE_NONE;
      pr_strong  = 0;
      pr_history = '{NONE_CODE, NONE_CODE, NONE_CODE};
      pr_slot    = 0;
      pr_held    = NONE_CODE;
      pr_rate    = NONE_CODE;
      pr_oxygen  = NONE_CODE;
   endfunction

   function automatic void predict_shown_values(level_type ir, raw_rate_type raw_rate,
                                                value_type raw_oxygen);
      int        rate;
      int        count;
      int        slot;
      int        lo;
      int        hi;
      int        median;
      int        diff;
      shown_type shown;
      rate = raw_rate;
      if (int'(ir) < cfg_absent) begin
         clear_tracking();
      end else if (int'(ir) < cfg_strong) begin
         if (pr_phase == PHASE_NONE) begin
            pr_phase  = PHASE_WARM;
            pr_rate   = NONE_CODE;
            pr_oxygen = NONE_CODE;
         end
      end else begin
         count = pr_strong + 1;
         if (count >= cfg_confirm || pr_phase == PHASE_STABLE) begin
            pr_phase = PHASE_STABLE;
            if (count > cfg_confirm)
               count = cfg_confirm;
            pr_strong = count & 15;
            pr_oxygen = raw_oxygen;
            if (rate >= cfg_rate_min && rate <= cfg_rate_max) begin
               slot = (pr_slot < 3) ? pr_slot : 0;
               pr_history[slot] = rate;
               pr_slot = (slot + 1) % 3;
               if (pr_history[0] >= cfg_rate_min && pr_history[1] >= cfg_rate_min &&
                   pr_history[2] >= cfg_rate_min) begin
                  lo = (pr_history[0] < pr_history[1]) ? pr_history[0] : pr_history[1];
                  hi = (pr_history[0] < pr_history[1]) ? pr_history[1] : pr_history[0];
                  median = (hi < pr_history[2]) ? hi : pr_history[2];
                  if (lo > median)
                     median = lo;
                  diff = median - pr_held;
                  if (diff < 0)
                     diff = -diff;
                  if (pr_held >= cfg_rate_min && diff > cfg_jump) begin
                     pr_rate = pr_held;
                  end else begin
                     pr_rate = median;
                     pr_held = median;
                  end
               end else begin
                  pr_rate = rate;
                  pr_held = rate;
               end
            end else begin
               pr_rate = (pr_held >= cfg_rate_min) ? pr_held : NONE_CODE;
            end
         end else begin
            pr_strong = count & 15;
            pr_rate   = NONE_CODE;
            pr_oxygen = NONE_CODE;
         end
      end
      shown.rate   = value_type'(pr_rate);
      shown.oxygen = value_type'(pr_oxygen);
      shown.status = pr_phase;
      shown_queue.push_back(shown);
   endfunction

   task automatic send_summary(level_type ir, raw_rate_type raw_rate, value_type raw_oxygen);
      while (int'($urandom_range(99)) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_ir_average <= ir;
      req_raw_rate   <= raw_rate;
      req_raw_oxygen <= raw_oxygen;
      do @(posedge clock); while (!req_ready);
      predict_shown_values(ir, raw_rate, raw_oxygen);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (shown_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type index, level_type value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(level_type absent, level_type strong_level,
                                 count_type confirm, bpm_type rate_low,
                                 bpm_type rate_high, bpm_type jump);
      write_register(CSR_ABSENT_THRESHOLD, absent);
      write_register(CSR_STRONG_THRESHOLD, strong_level);
      write_register(CSR_CONFIRM_WINDOWS, level_type'(confirm));
      write_register(CSR_RATE_MIN, level_type'(rate_low));
      write_register(CSR_RATE_MAX, level_type'(rate_high));
      write_register(CSR_JUMP_LIMIT, level_type'(jump));
      csr_write    <= 1'b0;
      cfg_absent   = absent;
      cfg_strong   = strong_level;
      cfg_confirm  = confirm;
      cfg_rate_min = rate_low;
      cfg_rate_max = rate_high;
      cfg_jump     = jump;
   endtask

   task automatic send_random_window();
      int        pick;
      int        rate;
      int        oxygen;
      level_type ir;
      pick = $urandom_range(99);
      if (pick < 8) begin
         if (cfg_absent > 0)
            ir = level_type'($urandom_range(cfg_absent - 1, 0));
         else
            ir = level_type'($urandom_range(262143, 0));
      end else if (pick < 20) begin
         if (cfg_strong > cfg_absent)
            ir = ($urandom_range(9) == 0) ? level_type'(cfg_absent)
                                           : level_type'($urandom_range(cfg_strong - 1,
                                                                        cfg_absent));
         else
            ir = level_type'($urandom_range(262143, 0));
      end else begin
         ir = ($urandom_range(9) == 0) ? level_type'(cfg_strong)
                                        : level_type'($urandom_range(262143, cfg_strong));
      end

      if (cfg_rate_min <= cfg_rate_max) begin
         if ($urandom_range(99) < 5)
            rate_center = $urandom_range(cfg_rate_max, cfg_rate_min);
         else
            rate_center = rate_center + int'($urandom_range(6)) - 3;
         if (rate_center < cfg_rate_min)
            rate_center = cfg_rate_min;
         if (rate_center > cfg_rate_max)
            rate_center = cfg_rate_max;
      end
      pick = $urandom_range(99);
      if (pick < 75)
         rate = rate_center;
      else if (pick < 85)
         rate = NO_RATE;
      else if (pick < 92)
         rate = $urandom_range(255, 0);
      else
         rate = int'($urandom_range(6999)) - 999;

      pick = $urandom_range(99);
      if (pick < 80)
         oxygen = $urandom_range(100, 85);
      else if (pick < 90)
         oxygen = NONE_CODE;
      else
         oxygen = int'($urandom_range(1126)) - 999;

      send_summary(ir, raw_rate_type'(rate), value_type'(oxygen));
   endtask

   task automatic test_directed_sequence();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      send_summary(18'd0, NO_RATE, NONE_CODE);
      send_summary(18'd7999, 14'sd75, 11'sd97);
      send_summary(18'd8000, 14'sd75, 11'sd97);
      send_summary(18'd14999, 14'sd75, 11'sd97);
      send_summary(18'd15000, 14'sd75, 11'sd97);
      send_summary(18'd15000, 14'sd76, 11'sd97);
      send_summary(18'd262143, 14'sd60, 11'sd98);
      send_summary(18'd20000, 14'sd62, 11'sd127);
      send_summary(18'd20000, 14'sd64, NONE_CODE);
      send_summary(18'd20000, 14'sd200, 11'sd99);
      send_summary(18'd20000, 14'sd221, 11'sd99);
      send_summary(18'd20000, 14'sd29, 11'sd99);
      send_summary(18'd20000, 14'sd30, 11'sd99);
      send_summary(18'd20000, 14'sd220, 11'sd99);
      send_summary(18'd20000, NO_RATE, 11'sd99);
      send_summary(18'd20000, 14'sd6000, 11'sd99);
      send_summary(18'd20000, 14'sd150, 11'sd99);
      send_summary(18'd20000, 14'sd150, 11'sd99);
      send_summary(18'd20000, 14'sd150, 11'sd99);
      send_summary(18'd9000, 14'sd80, 11'sd90);
      send_summary(18'd20000, -14'sd1, -11'sd1);
      send_summary(18'd0, 14'sd80, 11'sd90);
      wait_for_idle();
   endtask

   task automatic test_register_settings();
      level_type absent_set [8] = '{18'd0, 18'd262143, 18'd8000, 18'd20000, 18'd1000,
                                    18'd8000, 18'd8000, RESET_ABSENT_THRESHOLD};
      level_type strong_set [8] = '{18'd0, 18'd262143, 18'd15000, 18'd10000, 18'd2000,
                                    18'd15000, 18'd15000, RESET_STRONG_THRESHOLD};
      count_type confirm_set [8] = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd4, 4'd3, 4'd3,
                                     RESET_CONFIRM_WINDOWS};
      bpm_type   low_set [8] = '{8'd0, 8'd255, 8'd30, 8'd100, 8'd60, 8'd30, 8'd150,
                                 RESET_RATE_MIN};
      bpm_type   high_set [8] = '{8'd255, 8'd255, 8'd220, 8'd60, 8'd120, 8'd220, 8'd220,
                                  RESET_RATE_MAX};
      bpm_type   jump_set [8] = '{8'd0, 8'd255, 8'd30, 8'd10, 8'd5, 8'd30, 8'd30,
                                  RESET_JUMP_LIMIT};
      for (int s = 0; s < 8; s++) begin
         sender_gap_pct     = (s % 2 == 1) ? 49 : 0;
         receiver_stall_pct = (s % 4 >= 2) ? 49 : 0;
         apply_settings(absent_set[s], strong_set[s], confirm_set[s], low_set[s],
                        high_set[s], jump_set[s]);
         for (int n = 0; n < 60; n++)
            send_random_window();
         wait_for_idle();
      end
   endtask

   task automatic test_random_windows();
      int gap_set [4]   = '{0, 49, 0, 17};
      int stall_set [4] = '{0, 0, 49, 17};
      for (int p = 0; p < 4; p++) begin
         sender_gap_pct     = gap_set[p];
         receiver_stall_pct = stall_set[p];
         for (int n = 0; n < 320; n++) begin
            if (p == 2 && n == 160)
               wait_for_idle();
            send_random_window();
         end
      end
      wait_for_idle();
   endtask

   initial begin
      cfg_absent   = RESET_ABSENT_THRESHOLD;
      cfg_strong   = RESET_STRONG_THRESHOLD;
      cfg_confirm  = RESET_CONFIRM_WINDOWS;
      cfg_rate_min = RESET_RATE_MIN;
      cfg_rate_max = RESET_RATE_MAX;
      cfg_jump     = RESET_JUMP_LIMIT;
      clear_tracking();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_sequence();
      test_register_settings();
      test_random_windows();
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
src/prfq_pkg.sv
src/prfq_csr.sv
src/prfq_finger.sv
src/prfq_rate.sv
src/pulse_rate_finger_qualifier.sv
src/prfq_checker.sv
dv/tb_pulse_rate_finger_qualifier.sv
